// ----- sv/ssd_pkg.sv -----
// shared types and constants for the descending shaker sort block
// used by the controller, the datapath and the top level

package ssd_pkg;

  localparam int unsigned SSD_DEPTH  = 64;
  localparam int unsigned SSD_DATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_FSTART,
    ST_FRUN,
    ST_FEND,
    ST_BSTART,
    ST_BRUN,
    ST_BEND,
    ST_ERD,
    ST_ELD
  } state_e;

  // what goes into the store on a write
  typedef enum logic [1:0] {
    WSEL_INPUT,
    WSEL_MAX,
    WSEL_MIN,
    WSEL_CARRY
  } wsel_e;

  // what the carry register takes
  typedef enum logic [1:0] {
    CSEL_HOLD,
    CSEL_READ,
    CSEL_MAX,
    CSEL_MIN
  } csel_e;

  typedef struct packed {
    logic  in_store;
    logic  wr_en;
    wsel_e wr_sel;
    logic  rd_en;
    csel_e carry_sel;
    logic  out_load;
    logic  out_last;
    logic  set_clr;
  } cmd_t;

endpackage

// ----- sv/ssd_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies

module ssd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/ssd_datapath.sv -----
// datapath: element store, carry register with compare, fill count and output register
// depends on ssd_pkg and ssd_ram

module ssd_datapath #(
  parameter int unsigned DEPTH  = ssd_pkg::SSD_DEPTH,
  parameter int unsigned DATA_W = ssd_pkg::SSD_DATA_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssd_pkg::cmd_t              cmd_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  logic [DATA_W-1:0]          in_value_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic                       out_free_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [DATA_W-1:0]          out_value_o,
  output logic                       out_last_o,
  output logic                       out_ovf_o
);
  import ssd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [DATA_W-1:0] carry_q, carry_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic              out_last_q, out_ovf_q;

  logic              full;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic              rd_gt;
  logic [DATA_W-1:0] big, little;

  assign full   = (count_q == CW'(DEPTH));
  assign rd_gt  = $signed(rdata) > $signed(carry_q);
  assign big    = rd_gt ? rdata : carry_q;
  assign little = rd_gt ? carry_q : rdata;

  always_comb begin
    we    = cmd_i.wr_en;
    waddr = wr_addr_i;
    unique case (cmd_i.wr_sel)
      WSEL_INPUT: wdata = in_value_i;
      WSEL_MAX:   wdata = big;
      WSEL_MIN:   wdata = little;
      default:    wdata = carry_q;
    endcase
    if (cmd_i.in_store) begin
      we    = !full;
      waddr = count_q[AW-1:0];
      wdata = in_value_i;
    end
  end

  ssd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.in_store) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.set_clr) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
  end

  always_comb begin
    unique case (cmd_i.carry_sel)
      CSEL_READ: carry_d = rdata;
      CSEL_MAX:  carry_d = big;
      CSEL_MIN:  carry_d = little;
      default:   carry_d = carry_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (cmd_i.out_load) begin
      out_value_q <= rdata;
      out_last_q  <= cmd_i.out_last;
      out_ovf_q   <= dropped_q;
    end
  end

  assign count_o     = count_q;
  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// ----- sv/ssd_ctrl.sv -----
// controller: load, forward and backward bubble passes, and emit sequencing
// depends on ssd_pkg

module ssd_ctrl #(
  parameter int unsigned DEPTH = ssd_pkg::SSD_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_last_i,
  output logic                       in_ready_o,
  input  logic [$clog2(DEPTH+1)-1:0] count_i,
  input  logic                       out_free_i,
  output ssd_pkg::cmd_t              cmd_o,
  output logic [$clog2(DEPTH)-1:0]   wr_addr_o,
  output logic [$clog2(DEPTH)-1:0]   rd_addr_o
);
  import ssd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e        state_q, state_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_m1;
  logic          in_fire;
  logic          k_last;

  assign cnt_m1  = count_i - CW'(1);
  assign in_fire = in_valid_i && (state_q == ST_IDLE);
  assign k_last  = ((CW'(k_q) + CW'(1)) == count_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire && in_last_i) state_d = ST_INIT;
      ST_INIT:   state_d = ST_CHECK;
      ST_CHECK:  state_d = (lo_q < hi_q) ? ST_FSTART : ST_ERD;
      ST_FSTART: state_d = ST_FRUN;
      ST_FRUN:   if (ptr_q == hi_q) state_d = ST_FEND;
      ST_FEND:   state_d = ST_BSTART;
      ST_BSTART: state_d = ST_BRUN;
      ST_BRUN:   if (ptr_q == lo_q) state_d = ST_BEND;
      ST_BEND:   state_d = ST_CHECK;
      ST_ERD:    if (out_free_i) state_d = ST_ELD;
      ST_ELD:    state_d = k_last ? ST_IDLE : ST_ERD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '{in_store: 1'b0, wr_en: 1'b0, wr_sel: WSEL_INPUT, rd_en: 1'b0,
                   carry_sel: CSEL_HOLD, out_load: 1'b0, out_last: 1'b0, set_clr: 1'b0};
    wr_addr_o  = ptr_q;
    rd_addr_o  = ptr_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.in_store = in_fire;
      end
      ST_FSTART: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = lo_q;
      end
      ST_FRUN: begin
        if (ptr_q == lo_q) begin
          cmd_o.carry_sel = CSEL_READ;
        end else begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = WSEL_MAX;
          wr_addr_o       = ptr_q - AW'(1);
          cmd_o.carry_sel = CSEL_MIN;
        end
        if (ptr_q != hi_q) begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = ptr_q + AW'(1);
        end
      end
      ST_FEND: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WSEL_CARRY;
        wr_addr_o    = hi_q;
      end
      ST_BSTART: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = hi_q;
      end
      ST_BRUN: begin
        if (ptr_q == hi_q) begin
          cmd_o.carry_sel = CSEL_READ;
        end else begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = WSEL_MIN;
          wr_addr_o       = ptr_q + AW'(1);
          cmd_o.carry_sel = CSEL_MAX;
        end
        if (ptr_q != lo_q) begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = ptr_q - AW'(1);
        end
      end
      ST_BEND: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WSEL_CARRY;
        wr_addr_o    = lo_q;
      end
      ST_ERD: begin
        cmd_o.rd_en = out_free_i;
        rd_addr_o   = k_q;
      end
      ST_ELD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = k_last;
        cmd_o.set_clr  = k_last;
      end
      default: begin
      end
    endcase
  end

  // bound, pointer and emit index updates
  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    ptr_d = ptr_q;
    k_d   = k_q;
    unique case (state_q)
      ST_INIT: begin
        lo_d = '0;
        hi_d = cnt_m1[AW-1:0];
      end
      ST_CHECK:  k_d = '0;
      ST_FSTART: ptr_d = lo_q;
      ST_FRUN:   if (ptr_q != hi_q) ptr_d = ptr_q + AW'(1);
      ST_FEND:   hi_d = hi_q - AW'(1);
      ST_BSTART: ptr_d = hi_q;
      ST_BRUN:   if (ptr_q != lo_q) ptr_d = ptr_q - AW'(1);
      ST_BEND:   lo_d = lo_q + AW'(1);
      ST_ELD:    if (!k_last) k_d = k_q + AW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      ptr_q   <= ptr_d;
      k_q     <= k_d;
    end
  end

endmodule

// ----- sv/shaker_sort_descending_core.sv -----
// top level of the descending cocktail shaker sort block
// depends on ssd_pkg, ssd_ctrl, ssd_datapath and ssd_ram
//
// channel   dir  tdata          tlast     tuser
// s_axis    in   value[31:0]    last      -
// m_axis    out  sorted[31:0]   last_out  overflow
//
// loading accepts one request per cycle while idle; tready drops after the last one
// each result needs a store read, then the output register load
// a stalled output holds the register and pauses the emit sequence; no items are lost
// reset clears control state; the store holds stale data that is never read

module shaker_sort_descending_core #(
  parameter int unsigned DEPTH = ssd_pkg::SSD_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ssd_pkg::SSD_DATA_W-1:0] s_axis_tdata,  // value
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ssd_pkg::SSD_DATA_W-1:0] m_axis_tdata,  // sorted_value
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser   // overflow
);
  import ssd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;
  logic          out_free;

  ssd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .count_i   (count),
    .out_free_i(out_free),
    .cmd_o     (cmd),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr)
  );

  ssd_datapath #(
    .DEPTH (DEPTH),
    .DATA_W(SSD_DATA_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .rd_addr_i  (rd_addr),
    .in_value_i (s_axis_tdata),
    .count_o    (count),
    .out_free_o (out_free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_ovf_o  (m_axis_tuser)
  );

endmodule

// ----- sv/ssd_checker.sv -----
// port-level checks for the descending shaker sort block, bound to the top level
// depends on ssd_pkg and shaker_sort_descending_core

module ssd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ssd_pkg::SSD_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // the final request of a set starts the sort and closes the input
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after last request");

  // loading continues until the final request
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("input closed in the middle of a set");

  // each result takes a fresh store read before the next one
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result offered without a store read");

endmodule

bind shaker_sort_descending_core ssd_checker u_ssd_checker (.*);

// ----- sim/shaker_sort_descending_core_tb.sv -----
// self-checking testbench for shaker_sort_descending_core: directed table, then random sets
// predicts every sorted run in-bench and checks each output request field by field
// depends on ssd_pkg and the shaker_sort_descending_core rtl

module shaker_sort_descending_core_tb;

  import ssd_pkg::*;

  localparam int unsigned DEPTH       = SSD_DEPTH;
  localparam int unsigned RAND_ITEMS  = 385;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned NUM_DIR     = 21;

  localparam logic [31:0] V_MIN  = 32'h8000_0000;
  localparam logic [31:0] V_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] V_ZERO = 32'h0000_0000;
  localparam logic [31:0] V_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] sorted_value;
    logic        last_out;
    logic        overflow;
  } sorted_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        typed;
    logic [31:0] typed_value;
  } dir_row_t;

  // single-value sets carry a typed-in result, the rest go through the predictor
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{V_MIN,        1'b1, 1'b1, V_MIN},
    '{V_MAX,        1'b1, 1'b1, V_MAX},
    '{V_ZERO,       1'b1, 1'b1, V_ZERO},
    '{V_NEG1,       1'b1, 1'b1, V_NEG1},
    '{32'h0001_0000, 1'b0, 1'b0, V_ZERO},
    '{32'hFFFF_0000, 1'b1, 1'b0, V_ZERO},
    '{32'h0005_0000, 1'b0, 1'b0, V_ZERO},
    '{32'h0005_0000, 1'b0, 1'b0, V_ZERO},
    '{32'h0005_0000, 1'b1, 1'b0, V_ZERO},
    '{V_MAX,        1'b0, 1'b0, V_ZERO},
    '{V_ZERO,       1'b0, 1'b0, V_ZERO},
    '{V_MIN,        1'b1, 1'b0, V_ZERO},
    '{V_MIN,        1'b0, 1'b0, V_ZERO},
    '{V_NEG1,       1'b0, 1'b0, V_ZERO},
    '{V_ZERO,       1'b0, 1'b0, V_ZERO},
    '{32'h0000_0001, 1'b0, 1'b0, V_ZERO},
    '{V_MAX,        1'b1, 1'b0, V_ZERO},
    '{32'h5555_5555, 1'b0, 1'b0, V_ZERO},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, V_ZERO},
    '{32'h8000_0001, 1'b0, 1'b0, V_ZERO},
    '{32'h7FFF_FFFE, 1'b1, 1'b0, V_ZERO}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  sorted_res_t pending_results [$];
  logic [31:0] set_store [$];
  bit          set_dropped;
  bit          long_hold_req;
  bit          long_hold_active;

  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned sets_done;
  int unsigned overflow_sets;
  int unsigned results_seen;
  int unsigned cycle_count;

  shaker_sort_descending_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // stores one request and, on the last one, sorts the set descending and queues its run
  task automatic take_request(input logic [31:0] v, input logic l, input bit typed,
                              input logic [31:0] typed_v);
    logic signed [31:0] work [DEPTH];
    logic signed [31:0] t;
    int n;
    int lo;
    int hi;
    if (set_store.size() < DEPTH) set_store.push_back(v);
    else set_dropped = 1'b1;
    if (l) begin
      n = set_store.size();
      for (int i = 0; i < n; i++) work[i] = set_store[i];
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        for (int j = lo; j < hi; j++) begin
          if (work[j + 1] > work[j]) begin
            t = work[j];
            work[j] = work[j + 1];
            work[j + 1] = t;
          end
        end
        hi--;
        for (int j = hi; j > lo; j--) begin
          if (work[j] > work[j - 1]) begin
            t = work[j];
            work[j] = work[j - 1];
            work[j - 1] = t;
          end
        end
        lo++;
      end
      if (typed) begin
        pending_results.push_back(sorted_res_t'{sorted_value: typed_v, last_out: 1'b1,
                                                overflow: 1'b0});
      end else begin
        for (int k = 0; k < n; k++) begin
          pending_results.push_back(sorted_res_t'{sorted_value: work[k],
                                                  last_out: (k == n - 1),
                                                  overflow: set_dropped});
        end
      end
      sets_done++;
      if (set_dropped) overflow_sets++;
      set_store.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic send_request(input logic [31:0] v, input logic l, input int gap,
                              input bit typed, input logic [31:0] typed_v);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    take_request(v, l, typed, typed_v);
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    case (r)
      5: v = $urandom_range(0, 31) - 16;
      6: begin
        case ($urandom_range(0, 3))
          0: v = V_MIN;
          1: v = V_MAX;
          2: v = V_ZERO;
          default: v = V_NEG1;
        endcase
      end
      7: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0001_0000;
          1: v = 32'hFFFF_0000;
          2: v = 32'h0000_8000;
          default: v = V_MAX;
        endcase
      end
      8, 9: v = {16'($urandom_range(0, 255) - 128), 16'h0000};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_set(input int size, input bit no_gap);
    for (int i = 0; i < size; i++) begin
      send_request(pick_value(), (i == size - 1), no_gap ? 0 : pick_gap(), 1'b0, V_ZERO);
    end
  endtask

  task automatic drain_and_pause();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat ($urandom_range(1, 20)) @(negedge clk_i);
  endtask

  // receiver: bursts of full rate, random stalls, long stalls, and one counted hold-off
  initial begin
    int r;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      r = $urandom_range(0, 9);
      if (long_hold_req) begin
        long_hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(negedge clk_i);
        long_hold_req = 1'b0;
        long_hold_active = 1'b0;
      end else if (r < 3) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(5, 40)) @(negedge clk_i);
      end else if (r < 9) begin
        repeat ($urandom_range(5, 20)) begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
          @(negedge clk_i);
        end
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    sorted_res_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected output request: sorted_value %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (m_axis_tdata !== exp.sorted_value) begin
          $error("sorted_value expected %h actual %h", exp.sorted_value, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== exp.last_out) begin
          $error("last_out expected %b actual %b", exp.last_out, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== exp.overflow) begin
          $error("overflow expected %b actual %b", exp.overflow, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results still pending", cycle_count,
           pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int r;
    int size;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_request(DIR_ROWS[i].value, DIR_ROWS[i].last, pick_gap(), DIR_ROWS[i].typed,
                   DIR_ROWS[i].typed_value);
    end
    drain_and_pause();

    // output held off while requests keep coming: fills the block and stalls the input
    long_hold_req = 1'b1;
    wait (long_hold_active);
    send_set(4, 1'b1);
    send_set(DEPTH + 1, 1'b1);
    send_set(DEPTH, 1'b0);

    while (requests_sent < NUM_DIR + RAND_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) size = DEPTH + $urandom_range(1, 6);
      else if (r <= 2) size = $urandom_range(9, DEPTH);
      else size = $urandom_range(1, 8);
      send_set(size, ($urandom_range(0, 3) == 0));
      if ($urandom_range(0, 9) == 0) drain_and_pause();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("sent %0d requests in %0d sets (%0d with dropped requests), checked %0d results",
             requests_sent, sets_done, overflow_sets, results_seen);
    $display("in %0d cycles with random stalls on both sides", cycle_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
